>>> src/amph_pkg.sv
// Shared types and constants for the acceleration magnitude peak-hold block.
package amph_pkg;

	// Default axis width in bits (two's complement milli-g).
	localparam int AXIS_WIDTH_DEF = 14;

	// Axis select codes for the shared squaring multiplier.
	typedef enum logic [1:0] {
		AXIS_X = 2'd0,
		AXIS_Y = 2'd1,
		AXIS_Z = 2'd2
	} amph_axis_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic       load;
		logic       square;
		logic       root_start;
		logic       root_step;
		logic       finish;
		amph_axis_t sel;
	} amph_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic out_free;
	} amph_sts_t;

endpackage

>>> src/accel_magnitude_peak_hold.sv
// Each sample passes through the squaring of its three axes, the root loop (one root bit per
// cycle) and a finish step, which sets out_valid; a clear item goes straight to its finish step.
// Items are taken one at a time: no new sample or clear item is taken in until the last one has
// left its finish step. A finished result waits in the output register while the next item is
// taken in; an untaken result holds the next one in its finish state. Reset (arst_n low) clears
// the peak, state and output valid.
module accel_magnitude_peak_hold import amph_pkg::*; #(
	parameter int AXIS_WIDTH = AXIS_WIDTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic                  mode,
	input  logic [AXIS_WIDTH-1:0] accel_x,
	input  logic [AXIS_WIDTH-1:0] accel_y,
	input  logic [AXIS_WIDTH-1:0] accel_z,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [AXIS_WIDTH-1:0] magnitude,
	output logic [AXIS_WIDTH-1:0] peak
);

	amph_cmd_t cmd;
	amph_sts_t sts;

	// Controller: one item at a time, square three axes, then one root bit per cycle.
	amph_ctrl #(
		.AXIS_WIDTH(AXIS_WIDTH)
	) u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.mode    (mode),
		.in_ready(in_ready),
		.sts     (sts),
		.cmd     (cmd)
	);

	// Datapath: hold operands, accumulate squares, iterate the root, update the peak
	// and hold the result until its transfer.
	amph_dp #(
		.AXIS_WIDTH(AXIS_WIDTH)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.sts      (sts),
		.mode     (mode),
		.accel_x  (accel_x),
		.accel_y  (accel_y),
		.accel_z  (accel_z),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.magnitude(magnitude),
		.peak     (peak)
	);

endmodule

>>> src/amph_ctrl.sv
// Controller state machine: sequences squaring, root steps and result load.
module amph_ctrl import amph_pkg::*; #(
	parameter int AXIS_WIDTH = AXIS_WIDTH_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	input  logic      mode,
	output logic      in_ready,
	input  amph_sts_t sts,
	output amph_cmd_t cmd
);

	localparam int CNT_W = $clog2(AXIS_WIDTH);
	localparam logic [CNT_W-1:0] SQ_LAST   = CNT_W'(3);
	localparam logic [CNT_W-1:0] ROOT_LAST = CNT_W'(AXIS_WIDTH - 1);

	typedef enum logic [1:0] {
		S_IDLE,
		S_SQUARE,
		S_ROOT,
		S_FINISH
	} state_t;

	state_t           state_q;
	logic [CNT_W-1:0] cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					cnt_q <= '0;
					if (in_valid) begin
						state_q <= mode ? S_FINISH : S_SQUARE;
					end
				end
				S_SQUARE: begin
					if (cnt_q == SQ_LAST) begin
						cnt_q   <= '0;
						state_q <= S_ROOT;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				S_ROOT: begin
					if (cnt_q == ROOT_LAST) begin
						cnt_q   <= '0;
						state_q <= S_FINISH;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				S_FINISH: begin
					if (sts.out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_comb begin
		cmd            = '0;
		cmd.sel        = AXIS_X;
		in_ready       = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			S_SQUARE: begin
				cmd.square     = 1'b1;
				cmd.root_start = (cnt_q == SQ_LAST);
				unique case (cnt_q[1:0])
					2'd0:    cmd.sel = AXIS_X;
					2'd1:    cmd.sel = AXIS_Y;
					default: cmd.sel = AXIS_Z;
				endcase
			end
			S_ROOT: begin
				cmd.root_step = 1'b1;
			end
			S_FINISH: begin
				cmd.finish = sts.out_free;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

endmodule

>>> src/amph_dp.sv
// Datapath: axis magnitudes, shared squarer, digit-by-digit root, peak and output registers.
module amph_dp import amph_pkg::*; #(
	parameter int AXIS_WIDTH = AXIS_WIDTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  amph_cmd_t             cmd,
	output amph_sts_t             sts,
	input  logic                  mode,
	input  logic [AXIS_WIDTH-1:0] accel_x,
	input  logic [AXIS_WIDTH-1:0] accel_y,
	input  logic [AXIS_WIDTH-1:0] accel_z,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [AXIS_WIDTH-1:0] magnitude,
	output logic [AXIS_WIDTH-1:0] peak
);

	localparam int RAD_W = 2 * AXIS_WIDTH;
	localparam logic [RAD_W-1:0] PROBE_TOP = RAD_W'(1) << (RAD_W - 2);

	logic                  mode_q;
	logic [AXIS_WIDTH-1:0] ax_q, ay_q, az_q;
	logic [AXIS_WIDTH-1:0] op;
	logic [RAD_W-1:0]      prod_q, sum_q;
	logic [RAD_W-1:0]      rem_q, acc_q, probe_q;
	logic [RAD_W:0]        trial;
	logic                  fits;
	logic [AXIS_WIDTH-1:0] mag;
	logic [AXIS_WIDTH-1:0] peak_q, mag_q, peak_out_q;
	logic                  out_valid_q;

	function automatic logic [AXIS_WIDTH-1:0] abs_axis(input logic [AXIS_WIDTH-1:0] v);
		abs_axis = v[AXIS_WIDTH-1] ? (~v + 1'b1) : v;
	endfunction

	always_comb begin
		case (cmd.sel)
			AXIS_X:  op = ax_q;
			AXIS_Y:  op = ay_q;
			default: op = az_q;
		endcase
	end

	assign trial = {1'b0, acc_q} + {1'b0, probe_q};
	assign fits  = {1'b0, rem_q} >= trial;
	assign mag   = mode_q ? '0 : acc_q[AXIS_WIDTH-1:0];

	// Operand capture, squaring and root iteration carry no reset.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mode_q <= mode;
			ax_q   <= abs_axis(accel_x);
			ay_q   <= abs_axis(accel_y);
			az_q   <= abs_axis(accel_z);
			prod_q <= '0;
			sum_q  <= '0;
		end
		if (cmd.square) begin
			prod_q <= RAD_W'(op) * RAD_W'(op);
			sum_q  <= sum_q + prod_q;
		end
		if (cmd.root_start) begin
			rem_q   <= sum_q + prod_q;
			acc_q   <= '0;
			probe_q <= PROBE_TOP;
		end else if (cmd.root_step) begin
			if (fits) begin
				rem_q <= rem_q - trial[RAD_W-1:0];
				acc_q <= (acc_q >> 1) + probe_q;
			end else begin
				acc_q <= acc_q >> 1;
			end
			probe_q <= probe_q >> 2;
		end
		if (cmd.finish) begin
			mag_q <= mag;
			if (mode_q) begin
				peak_out_q <= '0;
			end else if (mag > peak_q) begin
				peak_out_q <= mag;
			end else begin
				peak_out_q <= peak_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			peak_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.finish) begin
				if (mode_q) begin
					peak_q <= '0;
				end else if (mag > peak_q) begin
					peak_q <= mag;
				end
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign sts.out_free = !out_valid_q || out_ready;
	assign out_valid    = out_valid_q;
	assign magnitude    = mag_q;
	assign peak         = peak_out_q;

endmodule

>>> src/amph_checker.sv
// Port-level checker for the magnitude peak-hold block, with its bind.
module amph_checker import amph_pkg::*; #(
	parameter int AXIS_WIDTH = AXIS_WIDTH_DEF
) (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  in_valid,
	input logic                  in_ready,
	input logic                  out_valid,
	input logic                  out_ready,
	input logic [AXIS_WIDTH-1:0] magnitude,
	input logic [AXIS_WIDTH-1:0] peak
);

	logic [AXIS_WIDTH-1:0] last_peak_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_peak_q <= '0;
		end else if (out_valid && out_ready) begin
			last_peak_q <= peak;
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(magnitude) && $stable(peak))
		else $error("result changed while stalled");

	a_peak_ge_mag: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> peak >= magnitude)
		else $error("peak below magnitude");

	a_peak_source: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (peak == magnitude) || (peak == last_peak_q))
		else $error("peak neither held nor taken from magnitude");

	a_peak_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (peak != '0) |-> peak >= last_peak_q)
		else $error("peak dropped without a clear");

	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("second item taken while one is in work");

endmodule

bind accel_magnitude_peak_hold amph_checker #(
	.AXIS_WIDTH(AXIS_WIDTH)
) u_amph_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.in_valid (in_valid),
	.in_ready (in_ready),
	.out_valid(out_valid),
	.out_ready(out_ready),
	.magnitude(magnitude),
	.peak     (peak)
);
